// ----- rtl/core/lcd_pkg.sv -----
// Package for the lock-order cycle detector: field widths, controller states,
// and the command and status structs between controller and datapath.
// Depends on nothing.
package lcd_pkg;

   localparam int LOCK_W      = 6;   // lock index width
   localparam int ROW_W       = 64;  // bits in one predecessor or reach row
   localparam int CNT_W       = 7;   // lock_count register width
   localparam int REQ_TDATA_W = 72;  // target_lock + predecessor_set, byte padded
   localparam int RSP_TDATA_W = 16;  // from_lock + to_lock + closes_cycle, byte padded

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_PICK,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic clear_wr;  // zero one row of both memories, advance sweep index
      logic accept;    // capture the request
      logic fetch;     // read the target's rows
      logic load;      // capture the target's rows, form the fresh set
      logic pick;      // take the lowest fresh edge, post its result
      logic pred_wr;   // write the target's predecessor row back
      logic scan_rd;   // read the next reach row of the sweep
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic target_ok;
      logic fresh_any;
      logic rsp_free;
      logic scan_last;
   } ctl_status_type;

endpackage

// ----- rtl/core/lcd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read at the address being written returns the old contents. No dependencies.
module lcd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/lcd_ctrl.sv -----
// Controller state machine of the lock-order cycle detector.
// Depends on lcd_pkg for the state enum and the command/status structs.
module lcd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lcd_pkg::ctl_status_type status,
   output lcd_pkg::ctl_cmd_type    cmd
);

   lcd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcd_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcd_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = lcd_pkg::ST_IDLE;
         end
         lcd_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = lcd_pkg::ST_FETCH;
         end
         lcd_pkg::ST_FETCH: begin
            state_in = status.target_ok ? lcd_pkg::ST_LOAD : lcd_pkg::ST_IDLE;
         end
         lcd_pkg::ST_LOAD: begin
            state_in = lcd_pkg::ST_PICK;
         end
         lcd_pkg::ST_PICK: begin
            priority if (!status.fresh_any) state_in = lcd_pkg::ST_IDLE;
            else if (status.rsp_free)       state_in = lcd_pkg::ST_SCAN;
         end
         lcd_pkg::ST_SCAN: begin
            if (status.scan_last) state_in = lcd_pkg::ST_DRAIN;
         end
         lcd_pkg::ST_DRAIN: begin
            state_in = lcd_pkg::ST_PICK;
         end
         default: state_in = lcd_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         lcd_pkg::ST_CLEAR: cmd.clear_wr = 1'b1;
         lcd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         lcd_pkg::ST_FETCH: cmd.fetch = status.target_ok;
         lcd_pkg::ST_LOAD:  cmd.load  = 1'b1;
         lcd_pkg::ST_PICK: begin
            cmd.pred_wr = !status.fresh_any;
            cmd.pick    = status.fresh_any && status.rsp_free;
         end
         lcd_pkg::ST_SCAN:  cmd.scan_rd = 1'b1;
         lcd_pkg::ST_DRAIN: cmd = '0;
         default: cmd = '0;
      endcase
   end

endmodule

// ----- rtl/core/lcd_datapath.sv -----
// Datapath of the lock-order cycle detector: row memories, edge selection,
// reach sweep and result register. Depends on lcd_pkg and lcd_ram.
module lcd_datapath #(
   parameter int LOCKS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [lcd_pkg::CNT_W-1:0]        csr_wr_data,
   input  logic [lcd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  lcd_pkg::ctl_cmd_type             cmd,
   output lcd_pkg::ctl_status_type          status,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lcd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int AW = $clog2(LOCKS);

   logic [lcd_pkg::CNT_W-1:0]  lock_count_ff, lock_count_in;
   logic [lcd_pkg::LOCK_W-1:0] target_ff, target_in;
   logic [lcd_pkg::ROW_W-1:0]  preds_ff, preds_in;
   logic [lcd_pkg::ROW_W-1:0]  pred_row_ff, pred_row_in;
   logic [lcd_pkg::ROW_W-1:0]  reach_to_ff, reach_to_in;
   logic [lcd_pkg::ROW_W-1:0]  fresh_ff, fresh_in;
   logic [lcd_pkg::ROW_W-1:0]  add_ff, add_in;
   logic [lcd_pkg::LOCK_W-1:0] from_ff, from_in;
   logic [AW-1:0]              scan_idx_ff, scan_idx_in;
   logic [AW-1:0]              scan_row_ff, scan_row_in;
   logic                       scan_vld_ff, scan_vld_in;
   logic [AW-1:0]              clr_idx_ff, clr_idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lcd_pkg::LOCK_W-1:0] rsp_from_ff, rsp_from_in;
   logic [lcd_pkg::LOCK_W-1:0] rsp_to_ff, rsp_to_in;
   logic                       rsp_cyc_ff, rsp_cyc_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [lcd_pkg::CNT_W-1:0]  eff_count;
   logic [lcd_pkg::ROW_W-1:0]  count_mask;
   logic [lcd_pkg::ROW_W-1:0]  target_bit;
   logic [lcd_pkg::ROW_W-1:0]  low_bit;
   logic [lcd_pkg::ROW_W-1:0]  rest;
   logic [lcd_pkg::LOCK_W-1:0] low_idx;
   logic [AW-1:0]              target_addr;
   logic                       scan_hit;
   logic                       rsp_free;

   logic                       reach_wr_en, pred_wr_en;
   logic [AW-1:0]              reach_wr_addr, pred_wr_addr, reach_rd_addr;
   logic [lcd_pkg::ROW_W-1:0]  reach_wr_data, pred_wr_data, reach_rd, pred_rd;

   assign eff_count = (lock_count_ff > lcd_pkg::CNT_W'(LOCKS)) ?
                      lcd_pkg::CNT_W'(LOCKS) : lock_count_ff;

   always_comb begin
      for (int b = 0; b < lcd_pkg::ROW_W; b++) begin
         count_mask[b] = lcd_pkg::CNT_W'(b) < eff_count;
      end
   end

   assign target_addr = target_ff[AW-1:0];
   assign target_bit  = lcd_pkg::ROW_W'(1) << target_ff;

   // isolate the lowest fresh predecessor and encode it
   assign low_bit = fresh_ff & (~fresh_ff + lcd_pkg::ROW_W'(1));
   assign rest    = fresh_ff & ~low_bit;

   always_comb begin
      low_idx = '0;
      for (int b = 0; b < lcd_pkg::ROW_W; b++) begin
         if (low_bit[b]) low_idx = low_idx | lcd_pkg::LOCK_W'(b);
      end
   end

   assign scan_hit = scan_vld_ff &&
                     (scan_row_ff == from_ff[AW-1:0] || reach_rd[from_ff]);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // memory ports
   assign reach_wr_en   = cmd.clear_wr || scan_hit;
   assign reach_wr_addr = cmd.clear_wr ? clr_idx_ff : scan_row_ff;
   assign reach_wr_data = cmd.clear_wr ? '0 : (reach_rd | add_ff);
   assign reach_rd_addr = cmd.fetch ? target_addr : scan_idx_ff;
   assign pred_wr_en    = cmd.clear_wr || cmd.pred_wr;
   assign pred_wr_addr  = cmd.clear_wr ? clr_idx_ff : target_addr;
   assign pred_wr_data  = cmd.clear_wr ? '0 : pred_row_ff;

   lcd_ram #(.WIDTH(lcd_pkg::ROW_W), .DEPTH(LOCKS)) u_reach_ram (
      .clock   (clock),
      .wr_en   (reach_wr_en),
      .wr_addr (reach_wr_addr),
      .wr_data (reach_wr_data),
      .rd_addr (reach_rd_addr),
      .rd_data (reach_rd)
   );

   lcd_ram #(.WIDTH(lcd_pkg::ROW_W), .DEPTH(LOCKS)) u_pred_ram (
      .clock   (clock),
      .wr_en   (pred_wr_en),
      .wr_addr (pred_wr_addr),
      .wr_data (pred_wr_data),
      .rd_addr (target_addr),
      .rd_data (pred_rd)
   );

   always_comb begin
      lock_count_in = lock_count_ff;
      target_in     = target_ff;
      preds_in      = preds_ff;
      pred_row_in   = pred_row_ff;
      reach_to_in   = reach_to_ff;
      fresh_in      = fresh_ff;
      add_in        = add_ff;
      from_in       = from_ff;
      scan_idx_in   = scan_idx_ff;
      scan_row_in   = scan_row_ff;
      scan_vld_in   = 1'b0;
      clr_idx_in    = clr_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_from_in   = rsp_from_ff;
      rsp_to_in     = rsp_to_ff;
      rsp_cyc_in    = rsp_cyc_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_wr_en) lock_count_in = csr_wr_data;
      if (cmd.clear_wr) clr_idx_in = clr_idx_ff + AW'(1);

      if (cmd.accept) begin
         target_in = req_tdata[lcd_pkg::LOCK_W-1:0];
         preds_in  = req_tdata[lcd_pkg::LOCK_W +: lcd_pkg::ROW_W];
      end

      if (cmd.load) begin
         pred_row_in = pred_rd;
         reach_to_in = reach_rd;
         fresh_in    = preds_ff & ~pred_rd & count_mask & ~target_bit;
      end

      if (cmd.pick) begin
         from_in      = low_idx;
         add_in       = reach_to_ff | target_bit;
         pred_row_in  = pred_row_ff | low_bit;
         fresh_in     = rest;
         scan_idx_in  = '0;
         rsp_valid_in = 1'b1;
         rsp_from_in  = low_idx;
         rsp_to_in    = target_ff;
         rsp_cyc_in   = |(reach_to_ff & low_bit);
         rsp_last_in  = (rest == '0);
      end

      if (cmd.scan_rd) begin
         scan_idx_in = scan_idx_ff + AW'(1);
         scan_row_in = scan_idx_ff;
         scan_vld_in = 1'b1;
      end

      // keep the local copy of the target's reach row in step with memory
      if (scan_hit && scan_row_ff == target_addr) reach_to_in = reach_to_ff | add_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_count_ff <= lcd_pkg::CNT_W'(64);
         scan_vld_ff   <= 1'b0;
         clr_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         lock_count_ff <= lock_count_in;
         scan_vld_ff   <= scan_vld_in;
         clr_idx_ff    <= clr_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      preds_ff    <= preds_in;
      pred_row_ff <= pred_row_in;
      reach_to_ff <= reach_to_in;
      fresh_ff    <= fresh_in;
      add_ff      <= add_in;
      from_ff     <= from_in;
      scan_idx_ff <= scan_idx_in;
      scan_row_ff <= scan_row_in;
      rsp_from_ff <= rsp_from_in;
      rsp_to_ff   <= rsp_to_in;
      rsp_cyc_ff  <= rsp_cyc_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.clear_last = (clr_idx_ff == AW'(LOCKS - 1));
   assign status.target_ok  = {1'b0, target_ff} < lcd_pkg::CNT_W'(LOCKS);
   assign status.fresh_any  = |fresh_ff;
   assign status.rsp_free   = rsp_free;
   assign status.scan_last  = (lcd_pkg::CNT_W'(scan_idx_ff) + lcd_pkg::CNT_W'(1)) == eff_count;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_cyc_ff, rsp_to_ff, rsp_from_ff};

endmodule

// ----- rtl/core/lock_order_cycle_detector_top.sv -----
// Top level of the lock-order cycle detector: ties controller and datapath.
// Depends on lcd_pkg, lcd_ctrl, lcd_datapath (and lcd_ram through it).
//
//   channel  dir  handshake           payload
//   req      in   req_tvalid/tready   tdata: target_lock, predecessor_set
//   rsp      out  rsp_tvalid/tready   tdata: from_lock, to_lock, closes_cycle; tlast
//   csr      in   csr_wr_en           csr_wr_data: lock_count
//
// After reset the block sweeps both row memories to zero with req_tready low;
// csr writes are taken during the sweep.
// One request runs accept, fetch, load, then per new edge a pick, a read of
// count reach rows and a drain, and ends with a closing pick that writes the
// predecessor row back; count is min(lock_count, LOCKS): the reach sweep reads
// one row per cycle through the single reach memory port. Worst case with
// LOCKS = 64 is 63 new edges (the target's own bit never counts).
// A stalled rsp holds the sweep before the next edge; req waits until the
// previous request has posted all its transfers into the result register.
module lock_order_cycle_detector_top #(
   parameter int LOCKS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: [5:0] target_lock, [69:6] predecessor_set, [71:70] zero
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lcd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // result: [5:0] from_lock, [11:6] to_lock, [12] closes_cycle, [15:13] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lcd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,   // last_edge
   // lock_count register
   input  logic                             csr_wr_en,
   input  logic [lcd_pkg::CNT_W-1:0]        csr_wr_data
);

   lcd_pkg::ctl_cmd_type    cmd;
   lcd_pkg::ctl_status_type status;

   // sequence: clear sweep, accept, fetch target rows, then per edge pick + sweep
   lcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // rows, edge selection, reach update and the result register
   lcd_datapath #(.LOCKS(LOCKS)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

`ifndef SYNTHESIS
   // the controller never issues two datapath operations in one cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.accept, cmd.fetch, cmd.load,
                cmd.pick, cmd.pred_wr, cmd.scan_rd}))
      else $error("controller issued overlapping commands");

   // an edge is posted only when the result register can take it
   a_pick_room: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> status.rsp_free)
      else $error("edge picked while result register full");

   // the target's rows are captured the cycle after they are read
   a_fetch_load: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> cmd.load)
      else $error("row fetch not followed by load");
`endif

endmodule
